@@ design/rtdt_pkg.sv @@
// Shared constants, codes and types for the resource timeline dispatch timer.
package rtdt_pkg;

    localparam int UNIT_IDX_BITS   = 2;
    localparam int UNITS_PER_CLASS = 1 << UNIT_IDX_BITS;
    localparam int NUM_CLASSES     = 3;
    localparam int NUM_UNITS       = NUM_CLASSES * UNITS_PER_CLASS;
    localparam int SLOT_BITS       = $clog2(NUM_UNITS);
    localparam int CLASS_BITS      = 2;

    localparam int TIME_BITS    = 48;
    localparam int BYTES_BITS   = 24;
    localparam int BUS_BITS     = 9;
    localparam int STARTUP_BITS = 16;
    localparam int DUR_BITS     = BYTES_BITS + 1;
    localparam int CNT_BITS     = $clog2(BYTES_BITS + 1);
    localparam int FUNC_BITS    = 3;
    localparam int COORD_BITS   = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [FUNC_BITS-1:0] FUNC_DMA      = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_MOVER    = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_STREAMER = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_BARRIER  = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_ONE_OP   = 3'd4;
    localparam logic [FUNC_BITS-1:0] FUNC_HALT     = 3'd5;

    localparam logic [CLASS_BITS-1:0] CLASS_NONE = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DMA_BUS          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DMA_STARTUP      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVER_BUS        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVER_STARTUP    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STREAMER_BUS     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STREAMER_STARTUP = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_TILE     = 3'd6;

    localparam logic [BUS_BITS-1:0]   BUS_RESET  = 9'd64;
    localparam logic [BYTES_BITS-1:0] TILE_RESET = 24'd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_START,
        S_END,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0]  func;
        logic [BYTES_BITS-1:0] transfer_bytes;
        logic [COORD_BITS-1:0] tile_row;
        logic [COORD_BITS-1:0] tile_col;
    } req_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  launch_cycle;
        logic [TIME_BITS-1:0]  end_cycle;
        logic [CLASS_BITS-1:0] unit_class;
        logic [1:0]            unit_index;
        logic [TIME_BITS-1:0]  total_span;
    } res_t;

    typedef struct packed {
        logic                  done;
        logic                  rem_nz;
        logic [BYTES_BITS-1:0] quotient;
    } div_res_t;

endpackage

@@ design/rtdt_divider.sv @@
// Restoring divider, one quotient bit per cycle, with remainder-nonzero flag.
module rtdt_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [rtdt_pkg::BYTES_BITS-1:0] dividend,
    input  logic [rtdt_pkg::BUS_BITS-1:0]   divisor,
    output rtdt_pkg::div_res_t              res
);

    logic [rtdt_pkg::BUS_BITS-1:0]   rem_reg;
    logic [rtdt_pkg::BYTES_BITS-1:0] quo_reg;
    logic [rtdt_pkg::BUS_BITS-1:0]   dsr_reg;
    logic [rtdt_pkg::CNT_BITS-1:0]   count_reg;
    logic                            running_reg;
    logic                            done_reg;

    logic [rtdt_pkg::BUS_BITS:0]     trial;
    logic [rtdt_pkg::BUS_BITS:0]     diff;
    logic                            fits;
    logic [rtdt_pkg::BUS_BITS-1:0]   rem_next;

    assign trial    = {rem_reg, quo_reg[rtdt_pkg::BYTES_BITS-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = fits ? diff[rtdt_pkg::BUS_BITS-1:0] : trial[rtdt_pkg::BUS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                running_reg <= 1'b1;
                count_reg   <= rtdt_pkg::CNT_BITS'(rtdt_pkg::BYTES_BITS);
            end
            else if (running_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == rtdt_pkg::CNT_BITS'(1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (running_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[rtdt_pkg::BYTES_BITS-2:0], fits};
        end
    end

    assign res.done     = done_reg;
    assign res.rem_nz   = rem_reg != '0;
    assign res.quotient = quo_reg;

endmodule

@@ design/resource_timeline_dispatch_timer.sv @@
// Resource timeline dispatch timer: top level. A request is taken when start is high and
// busy is low. DMA, block-mover and streamer requests pass from acceptance to the done
// strobe through the load, divide, start-time, end-time and update steps in turn; the shared
// divider forms ceil(bytes / bus width) one quotient bit per cycle, and busy stays
// high throughout. Barrier, one-cycle and halt requests give their result on the cycle
// after acceptance and leave busy low. Each result is shown for exactly one cycle with
// done and cannot be held off. Configuration writes are always accepted (cfg_ready is high)
// and belong in idle periods only. Times saturate at all ones.
module resource_timeline_dispatch_timer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rtdt_pkg::req_t                    request,
    output logic                              done,
    output rtdt_pkg::res_t                    result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtdt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rtdt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    rtdt_pkg::state_t state_reg, state_next;

    logic [rtdt_pkg::BUS_BITS-1:0]     bus_reg [rtdt_pkg::NUM_CLASSES];
    logic [rtdt_pkg::STARTUP_BITS-1:0] startup_reg [rtdt_pkg::NUM_CLASSES];
    logic [rtdt_pkg::BYTES_BITS-1:0]   tile_reg;

    logic [rtdt_pkg::TIME_BITS-1:0] free_reg [rtdt_pkg::NUM_UNITS];
    logic [rtdt_pkg::TIME_BITS-1:0] barrier_reg;
    logic [rtdt_pkg::TIME_BITS-1:0] current_reg;
    logic [rtdt_pkg::TIME_BITS-1:0] span_reg;

    logic [rtdt_pkg::BYTES_BITS-1:0] bytes_reg;
    logic [rtdt_pkg::CLASS_BITS-1:0] cls_reg;
    logic [rtdt_pkg::SLOT_BITS-1:0]  slot_reg;
    logic [rtdt_pkg::DUR_BITS-1:0]   dur_reg;
    logic [rtdt_pkg::TIME_BITS-1:0]  start_reg;
    logic [rtdt_pkg::TIME_BITS-1:0]  end_reg;
    rtdt_pkg::res_t                  res_reg;
    logic                            done_reg;

    logic                                accept;
    logic                                is_transfer;
    logic                                div_load;
    logic [rtdt_pkg::UNIT_IDX_BITS-1:0]  unit_idx;
    logic [rtdt_pkg::BUS_BITS-1:0]       bus_sel;
    logic [rtdt_pkg::BYTES_BITS-1:0]     bytes_sel;
    logic [rtdt_pkg::TIME_BITS-1:0]      cur_inc;
    logic [rtdt_pkg::TIME_BITS-1:0]      free_rd;
    logic [rtdt_pkg::TIME_BITS:0]        end_sum;
    logic [rtdt_pkg::TIME_BITS-1:0]      span_new;
    rtdt_pkg::div_res_t                  div_res;

    assign accept      = start && !busy;
    assign is_transfer = request.func <= rtdt_pkg::FUNC_STREAMER;
    assign unit_idx    = request.tile_row[rtdt_pkg::UNIT_IDX_BITS-1:0]
                       + request.tile_col[rtdt_pkg::UNIT_IDX_BITS-1:0];
    assign cfg_ready   = 1'b1;

    assign bus_sel   = (bus_reg[cls_reg] == '0) ? rtdt_pkg::BUS_BITS'(1) : bus_reg[cls_reg];
    assign bytes_sel = (bytes_reg == '0) ? tile_reg : bytes_reg;
    assign cur_inc   = (current_reg == rtdt_pkg::TIME_MAX) ? rtdt_pkg::TIME_MAX
                     : current_reg + rtdt_pkg::TIME_BITS'(1);
    assign free_rd   = free_reg[slot_reg];
    assign end_sum   = {1'b0, start_reg} + (rtdt_pkg::TIME_BITS + 1)'(dur_reg);
    assign span_new  = (end_reg > span_reg) ? end_reg : span_reg;

    rtdt_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (bytes_sel),
        .divisor  (bus_sel),
        .res      (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtdt_pkg::S_IDLE:
            begin
                if (accept && is_transfer)
                begin
                    state_next = rtdt_pkg::S_LOAD;
                end
            end
            rtdt_pkg::S_LOAD:  state_next = rtdt_pkg::S_DIV;
            rtdt_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = rtdt_pkg::S_START;
                end
            end
            rtdt_pkg::S_START: state_next = rtdt_pkg::S_END;
            rtdt_pkg::S_END:   state_next = rtdt_pkg::S_FIN;
            rtdt_pkg::S_FIN:   state_next = rtdt_pkg::S_IDLE;
            default:           state_next = rtdt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = 1'b1;
        div_load = 1'b0;
        unique case (state_reg)
            rtdt_pkg::S_IDLE: busy     = 1'b0;
            rtdt_pkg::S_LOAD: div_load = 1'b1;
            default:          busy     = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtdt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rtdt_pkg::NUM_CLASSES; k++)
            begin
                bus_reg[k]     <= rtdt_pkg::BUS_RESET;
                startup_reg[k] <= '0;
            end
            tile_reg <= rtdt_pkg::TILE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rtdt_pkg::CFG_DMA_BUS:          bus_reg[0]     <= cfg_data[rtdt_pkg::BUS_BITS-1:0];
                rtdt_pkg::CFG_DMA_STARTUP:      startup_reg[0] <= cfg_data[rtdt_pkg::STARTUP_BITS-1:0];
                rtdt_pkg::CFG_MOVER_BUS:        bus_reg[1]     <= cfg_data[rtdt_pkg::BUS_BITS-1:0];
                rtdt_pkg::CFG_MOVER_STARTUP:    startup_reg[1] <= cfg_data[rtdt_pkg::STARTUP_BITS-1:0];
                rtdt_pkg::CFG_STREAMER_BUS:     bus_reg[2]     <= cfg_data[rtdt_pkg::BUS_BITS-1:0];
                rtdt_pkg::CFG_STREAMER_STARTUP: startup_reg[2] <= cfg_data[rtdt_pkg::STARTUP_BITS-1:0];
                rtdt_pkg::CFG_DEFAULT_TILE:     tile_reg       <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // timeline state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rtdt_pkg::NUM_UNITS; k++)
            begin
                free_reg[k] <= '0;
            end
            barrier_reg <= '0;
            current_reg <= '0;
            span_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (accept)
            begin
                case (request.func) inside
                    rtdt_pkg::FUNC_DMA, rtdt_pkg::FUNC_MOVER, rtdt_pkg::FUNC_STREAMER: ;
                    rtdt_pkg::FUNC_BARRIER:
                    begin
                        barrier_reg <= span_reg;
                        current_reg <= span_reg;
                        done_reg    <= 1'b1;
                    end
                    rtdt_pkg::FUNC_HALT:
                    begin
                        done_reg <= 1'b1;
                    end
                    default:
                    begin
                        current_reg <= cur_inc;
                        done_reg    <= 1'b1;
                    end
                endcase
            end
            else if (state_reg == rtdt_pkg::S_FIN)
            begin
                free_reg[slot_reg] <= end_reg;
                current_reg        <= end_reg;
                span_reg           <= span_new;
                done_reg           <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= request.transfer_bytes;
            cls_reg   <= request.func[rtdt_pkg::CLASS_BITS-1:0];
            slot_reg  <= {request.func[rtdt_pkg::CLASS_BITS-1:0], unit_idx};
            case (request.func) inside
                rtdt_pkg::FUNC_DMA, rtdt_pkg::FUNC_MOVER, rtdt_pkg::FUNC_STREAMER: ;
                rtdt_pkg::FUNC_BARRIER:
                begin
                    res_reg <= {span_reg, span_reg, rtdt_pkg::CLASS_NONE, 2'd0, span_reg};
                end
                rtdt_pkg::FUNC_HALT:
                begin
                    res_reg <= {current_reg, current_reg, rtdt_pkg::CLASS_NONE, 2'd0, span_reg};
                end
                default:
                begin
                    res_reg <= {current_reg, cur_inc, rtdt_pkg::CLASS_NONE, 2'd0, span_reg};
                end
            endcase
        end
        else
        begin
            case (state_reg)
                rtdt_pkg::S_START:
                begin
                    start_reg <= (barrier_reg > free_rd) ? barrier_reg : free_rd;
                    dur_reg   <= rtdt_pkg::DUR_BITS'(startup_reg[cls_reg])
                               + rtdt_pkg::DUR_BITS'(div_res.quotient)
                               + rtdt_pkg::DUR_BITS'(div_res.rem_nz);
                end
                rtdt_pkg::S_END:
                begin
                    end_reg <= end_sum[rtdt_pkg::TIME_BITS] ? rtdt_pkg::TIME_MAX
                             : end_sum[rtdt_pkg::TIME_BITS-1:0];
                end
                rtdt_pkg::S_FIN:
                begin
                    res_reg <= {start_reg, end_reg, cls_reg,
                                2'(slot_reg[rtdt_pkg::UNIT_IDX_BITS-1:0]), span_new};
                end
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ design/rtdt_checker.sv @@
// Port-level assertions for the dispatch timer, bound to the top level.
module rtdt_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input rtdt_pkg::req_t                      request,
    input logic                                done,
    input rtdt_pkg::res_t                      result,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [rtdt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [rtdt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func > rtdt_pkg::FUNC_STREAMER) |=> (done && !busy))
        else $error("non-transfer request gave no result on the next cycle");

    a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func <= rtdt_pkg::FUNC_STREAMER) |=> (busy && !done))
        else $error("transfer request did not hold busy");

    a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.end_cycle >= result.launch_cycle))
        else $error("result ends before it starts");

endmodule

bind resource_timeline_dispatch_timer rtdt_checker u_rtdt_checker (.*);

@@ sim/resource_timeline_dispatch_timer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for resource_timeline_dispatch_timer: random and directed requests.
module resource_timeline_dispatch_timer_tb;

    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_REQUESTS = 365;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    rtdt_pkg::req_t                      request = '0;
    logic                                done;
    rtdt_pkg::res_t                      result;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [rtdt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [rtdt_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    resource_timeline_dispatch_timer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of configuration and timeline state
    logic [rtdt_pkg::BUS_BITS-1:0]     lane_bytes [rtdt_pkg::NUM_CLASSES];
    logic [rtdt_pkg::STARTUP_BITS-1:0] setup_cycles [rtdt_pkg::NUM_CLASSES];
    logic [rtdt_pkg::BYTES_BITS-1:0]   tile_bytes;
    logic [rtdt_pkg::TIME_BITS-1:0]    unit_free [rtdt_pkg::NUM_UNITS];
    logic [rtdt_pkg::TIME_BITS-1:0]    barrier_at;
    logic [rtdt_pkg::TIME_BITS-1:0]    now_at;
    logic [rtdt_pkg::TIME_BITS-1:0]    makespan;

    rtdt_pkg::req_t op_backlog [$];
    rtdt_pkg::res_t due_timings [$];
    int   queued = 0;
    int   taken = 0;
    int   errors = 0;
    int   gap_pct = 0;
    int   quiet_cycles = 0;

    function automatic logic [rtdt_pkg::TIME_BITS-1:0] add_sat(
        logic [rtdt_pkg::TIME_BITS-1:0] a, logic [rtdt_pkg::TIME_BITS-1:0] b);
        logic [rtdt_pkg::TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[rtdt_pkg::TIME_BITS] ? rtdt_pkg::TIME_MAX : sum[rtdt_pkg::TIME_BITS-1:0];
    endfunction

    function automatic rtdt_pkg::res_t schedule_request(rtdt_pkg::req_t op);
        rtdt_pkg::res_t                 r;
        longint unsigned                bus;
        longint unsigned                nbytes;
        logic [rtdt_pkg::TIME_BITS-1:0] span_len;
        int                             cls;
        int                             slot;
        r = '0;
        r.unit_class = rtdt_pkg::CLASS_NONE;
        case (op.func)
            rtdt_pkg::FUNC_DMA, rtdt_pkg::FUNC_MOVER, rtdt_pkg::FUNC_STREAMER:
            begin
                cls = op.func;
                bus = (lane_bytes[cls] == 0) ? 1 : lane_bytes[cls];
                nbytes = (op.transfer_bytes == 0) ? tile_bytes : op.transfer_bytes;
                span_len = rtdt_pkg::TIME_BITS'(setup_cycles[cls] + (nbytes + bus - 1) / bus);
                r.unit_class = cls[rtdt_pkg::CLASS_BITS-1:0];
                r.unit_index = 2'((int'(op.tile_row) + int'(op.tile_col))
                                  % rtdt_pkg::UNITS_PER_CLASS);
                slot = cls * rtdt_pkg::UNITS_PER_CLASS + r.unit_index;
                r.launch_cycle = (barrier_at > unit_free[slot]) ? barrier_at : unit_free[slot];
                r.end_cycle = add_sat(r.launch_cycle, span_len);
                unit_free[slot] = r.end_cycle;
                if (r.end_cycle > makespan)
                    makespan = r.end_cycle;
                now_at = r.end_cycle;
            end
            rtdt_pkg::FUNC_BARRIER:
            begin
                barrier_at = makespan;
                now_at = makespan;
                r.launch_cycle = makespan;
                r.end_cycle = makespan;
            end
            rtdt_pkg::FUNC_HALT:
            begin
                r.launch_cycle = now_at;
                r.end_cycle = now_at;
            end
            default:
            begin
                r.launch_cycle = now_at;
                r.end_cycle = add_sat(now_at, rtdt_pkg::TIME_BITS'(1));
                now_at = r.end_cycle;
            end
        endcase
        r.total_span = makespan;
        return r;
    endfunction

    function automatic void check_field(string name, logic [rtdt_pkg::TIME_BITS-1:0] want,
                                        logic [rtdt_pkg::TIME_BITS-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic rtdt_pkg::req_t make_op(logic [rtdt_pkg::FUNC_BITS-1:0] f,
                                               logic [rtdt_pkg::BYTES_BITS-1:0] n,
                                               logic [rtdt_pkg::COORD_BITS-1:0] row,
                                               logic [rtdt_pkg::COORD_BITS-1:0] col);
        rtdt_pkg::req_t op;
        op.func = f;
        op.transfer_bytes = n;
        op.tile_row = row;
        op.tile_col = col;
        return op;
    endfunction

    function automatic rtdt_pkg::req_t random_op();
        int                              pick;
        logic [rtdt_pkg::FUNC_BITS-1:0]  f;
        logic [rtdt_pkg::BYTES_BITS-1:0] n;
        pick = $urandom_range(99);
        if (pick < 30)
            f = rtdt_pkg::FUNC_DMA;
        else if (pick < 50)
            f = rtdt_pkg::FUNC_MOVER;
        else if (pick < 70)
            f = rtdt_pkg::FUNC_STREAMER;
        else if (pick < 80)
            f = rtdt_pkg::FUNC_BARRIER;
        else if (pick < 88)
            f = rtdt_pkg::FUNC_ONE_OP;
        else if (pick < 94)
            f = rtdt_pkg::FUNC_HALT;
        else
            f = rtdt_pkg::FUNC_BITS'($urandom_range(7));
        pick = $urandom_range(9);
        if (pick == 0)
            n = '0;
        else if (pick == 1)
            n = '1;
        else if (pick < 6)
            n = rtdt_pkg::BYTES_BITS'($urandom_range(4096));
        else
            n = rtdt_pkg::BYTES_BITS'($urandom());
        return make_op(f, n, rtdt_pkg::COORD_BITS'($urandom()),
                       rtdt_pkg::COORD_BITS'($urandom()));
    endfunction

    task automatic queue_op(rtdt_pkg::req_t op);
        op_backlog = {op_backlog, op};
        queued++;
    endtask

    task automatic write_reg(logic [rtdt_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [rtdt_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rtdt_pkg::CFG_DMA_BUS:          lane_bytes[0] = val[rtdt_pkg::BUS_BITS-1:0];
            rtdt_pkg::CFG_DMA_STARTUP:      setup_cycles[0] = val[rtdt_pkg::STARTUP_BITS-1:0];
            rtdt_pkg::CFG_MOVER_BUS:        lane_bytes[1] = val[rtdt_pkg::BUS_BITS-1:0];
            rtdt_pkg::CFG_MOVER_STARTUP:    setup_cycles[1] = val[rtdt_pkg::STARTUP_BITS-1:0];
            rtdt_pkg::CFG_STREAMER_BUS:     lane_bytes[2] = val[rtdt_pkg::BUS_BITS-1:0];
            rtdt_pkg::CFG_STREAMER_STARTUP: setup_cycles[2] = val[rtdt_pkg::STARTUP_BITS-1:0];
            rtdt_pkg::CFG_DEFAULT_TILE:     tile_bytes = val[rtdt_pkg::BYTES_BITS-1:0];
            default:                        ;
        endcase
    endtask

    task automatic drain();
        while (taken != queued || due_timings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: one request per handshake, held until busy drops
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                due_timings = {due_timings, schedule_request(request)};
                taken++;
            end
            if (!start || !busy)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    start   <= 1'b1;
                    request <= op_backlog.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        rtdt_pkg::res_t want;
        if (rst_n && done)
        begin
            if (due_timings.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = due_timings.pop_front();
                check_field("start_cycle", want.launch_cycle, result.launch_cycle);
                check_field("end_cycle", want.end_cycle, result.end_cycle);
                check_field("unit_class", want.unit_class, result.unit_class);
                check_field("unit_index", want.unit_index, result.unit_index);
                check_field("total_span", want.total_span, result.total_span);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("resource_timeline_dispatch_timer verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int k = 0; k < rtdt_pkg::NUM_CLASSES; k++)
        begin
            lane_bytes[k] = rtdt_pkg::BUS_RESET;
            setup_cycles[k] = '0;
        end
        tile_bytes = rtdt_pkg::TILE_RESET;
        for (int k = 0; k < rtdt_pkg::NUM_UNITS; k++)
            unit_free[k] = '0;
        barrier_at = '0;
        now_at = '0;
        makespan = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests on reset configuration
        queue_op(make_op(rtdt_pkg::FUNC_DMA, 24'd0, 16'd0, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_DMA, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        queue_op(make_op(rtdt_pkg::FUNC_MOVER, 24'd1, 16'd1, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_STREAMER, 24'd64, 16'd0, 16'd2));
        queue_op(make_op(rtdt_pkg::FUNC_STREAMER, 24'd65, 16'd3, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_ONE_OP, 24'd0, 16'd0, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_HALT, 24'd0, 16'd0, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_BARRIER, 24'd0, 16'd0, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_DMA, 24'd100, 16'd0, 16'd0));
        queue_op(make_op(3'd6, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        queue_op(make_op(3'd7, 24'd5, 16'd7, 16'd9));
        queue_op(make_op(rtdt_pkg::FUNC_MOVER, 24'd0, 16'hFFFF, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_HALT, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        queue_op(make_op(rtdt_pkg::FUNC_BARRIER, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        queue_op(make_op(rtdt_pkg::FUNC_STREAMER, 24'hAAAAAA, 16'h5555, 16'hAAAA));
        queue_op(make_op(rtdt_pkg::FUNC_DMA, 24'h555555, 16'hAAAA, 16'h5555));
        queue_op(make_op(rtdt_pkg::FUNC_ONE_OP, 24'd0, 16'd0, 16'd0));
        queue_op(make_op(rtdt_pkg::FUNC_BARRIER, 24'd0, 16'd0, 16'd0));
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(rtdt_pkg::CFG_DMA_BUS, 24'd1);
                    write_reg(rtdt_pkg::CFG_MOVER_BUS, 24'd1);
                    write_reg(rtdt_pkg::CFG_STREAMER_BUS, 24'd1);
                    write_reg(rtdt_pkg::CFG_DMA_STARTUP, 24'd0);
                    write_reg(rtdt_pkg::CFG_MOVER_STARTUP, 24'd0);
                    write_reg(rtdt_pkg::CFG_STREAMER_STARTUP, 24'd0);
                    write_reg(rtdt_pkg::CFG_DEFAULT_TILE, 24'd1);
                    gap_pct = 0;
                end
                1:
                begin
                    // zero bus width acts as one byte per cycle; upper data bits ignored
                    write_reg(rtdt_pkg::CFG_DMA_BUS, 24'd256);
                    write_reg(rtdt_pkg::CFG_MOVER_BUS, 24'hFFFE00);
                    write_reg(rtdt_pkg::CFG_STREAMER_BUS, 24'hABCFFF);
                    write_reg(rtdt_pkg::CFG_DMA_STARTUP, 24'd65535);
                    write_reg(rtdt_pkg::CFG_MOVER_STARTUP, 24'h12FFFF);
                    write_reg(rtdt_pkg::CFG_STREAMER_STARTUP, 24'd1);
                    write_reg(rtdt_pkg::CFG_DEFAULT_TILE, 24'hFFFFFF);
                    gap_pct = 71;
                end
                default:
                begin
                    for (int k = 0; k < rtdt_pkg::NUM_CLASSES; k++)
                    begin
                        write_reg(rtdt_pkg::CFG_INDEX_BITS'(rtdt_pkg::CFG_DMA_BUS + 2 * k),
                                  rtdt_pkg::CFG_DATA_BITS'($urandom_range(1, 256)));
                        write_reg(rtdt_pkg::CFG_INDEX_BITS'(rtdt_pkg::CFG_DMA_STARTUP + 2 * k),
                                  rtdt_pkg::CFG_DATA_BITS'($urandom_range(65535)));
                    end
                    // zero default tile leaves only the startup cycles
                    write_reg(rtdt_pkg::CFG_DEFAULT_TILE,
                              (ph == 2) ? 24'd0
                              : rtdt_pkg::CFG_DATA_BITS'($urandom_range(1, 24'hFFFFFF)));
                    gap_pct = (ph == 3) ? 9 : ((ph == 4) ? 71 : 0);
                end
            endcase
            for (int i = 0; i < PHASE_REQUESTS; i++)
                queue_op(random_op());
            drain();
        end

        if (errors == 0 && due_timings.size() == 0)
            $display("resource_timeline_dispatch_timer verification clean");
        else
            $display("resource_timeline_dispatch_timer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rtdt_pkg.sv
design/rtdt_divider.sv
design/resource_timeline_dispatch_timer.sv
design/rtdt_checker.sv
sim/resource_timeline_dispatch_timer_tb.sv
